FILE: sv/bvp_pkg.sv
// Shared types, curve tables and microprogram for battery_voltage_to_percent.
// No dependencies; every other file refers to this package by scoped names.
package bvp_pkg;

    localparam int CURVE_POINTS = 20;
    localparam int IDX_W        = $clog2(CURVE_POINTS);
    localparam int MV_W         = 16;
    localparam int PCT_W        = 7;
    localparam int PROD_W       = PCT_W + MV_W;
    localparam int REM_W        = MV_W;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef logic [MV_W-1:0]  mv_t;
    typedef logic [PCT_W-1:0] pct_t;

    // Single-cell LiPo discharge curve, millivolts and percent.
    localparam mv_t CURVE_MV [CURVE_POINTS] = '{
        16'd3270, 16'd3610, 16'd3690, 16'd3710, 16'd3730,
        16'd3750, 16'd3770, 16'd3790, 16'd3800, 16'd3820,
        16'd3840, 16'd3850, 16'd3870, 16'd3910, 16'd3950,
        16'd3980, 16'd4020, 16'd4080, 16'd4110, 16'd4150};
    localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
        7'd0,  7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
        7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd100};

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLAMP,
        OP_WALK,
        OP_MUL,
        OP_DIV_INT,
        OP_DIV_STEP,
        OP_ADD_PCT,
        OP_SEED,
        OP_AVG_SUM,
        OP_STORE,
        OP_EMIT,
        OP_EMIT_ERR
    } op_t;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_FAILED,
        C_OUT_RANGE,
        C_FOUND,
        C_DIV_LAST,
        C_VALID,
        C_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT  = 4'd0;
    localparam step_t ST_CHK   = 4'd1;
    localparam step_t ST_RANGE = 4'd2;
    localparam step_t ST_WALK  = 4'd3;
    localparam step_t ST_MUL   = 4'd4;
    localparam step_t ST_DIVI  = 4'd5;
    localparam step_t ST_DRUN1 = 4'd6;
    localparam step_t ST_ADDP  = 4'd7;
    localparam step_t ST_AVG   = 4'd8;
    localparam step_t ST_UPD   = 4'd9;
    localparam step_t ST_STORE = 4'd10;
    localparam step_t ST_OUT   = 4'd11;
    localparam step_t ST_FAIL  = 4'd12;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp_t;   // next step when the condition holds
        step_t jmp_f;   // next step otherwise
    } ctrl_t;

    // Microprogram ROM.
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t cw;
        case (pc)
            ST_WAIT:  cw = '{OP_NOP,      C_START,     ST_CHK,   ST_WAIT};
            ST_CHK:   cw = '{OP_CLAMP,    C_FAILED,    ST_FAIL,  ST_RANGE};
            ST_RANGE: cw = '{OP_CLAMP,    C_OUT_RANGE, ST_AVG,   ST_WALK};
            ST_WALK:  cw = '{OP_WALK,     C_FOUND,     ST_MUL,   ST_WALK};
            ST_MUL:   cw = '{OP_MUL,      C_ALWAYS,    ST_DIVI,  ST_DIVI};
            ST_DIVI:  cw = '{OP_DIV_INT,  C_ALWAYS,    ST_DRUN1, ST_DRUN1};
            ST_DRUN1: cw = '{OP_DIV_STEP, C_DIV_LAST,  ST_ADDP,  ST_DRUN1};
            ST_ADDP:  cw = '{OP_ADD_PCT,  C_ALWAYS,    ST_AVG,   ST_AVG};
            ST_AVG:   cw = '{OP_SEED,     C_VALID,     ST_UPD,   ST_OUT};
            ST_UPD:   cw = '{OP_AVG_SUM,  C_ALWAYS,    ST_STORE, ST_STORE};
            ST_STORE: cw = '{OP_STORE,    C_ALWAYS,    ST_OUT,   ST_OUT};
            ST_OUT:   cw = '{OP_EMIT,     C_OUT_BUSY,  ST_OUT,   ST_WAIT};
            ST_FAIL:  cw = '{OP_EMIT_ERR, C_OUT_BUSY,  ST_FAIL,  ST_WAIT};
            default:  cw = '{OP_NOP,      C_ALWAYS,    ST_WAIT,  ST_WAIT};
        endcase
        return cw;
    endfunction

endpackage

FILE: sv/battery_voltage_to_percent.sv
// Top level of battery_voltage_to_percent: microcoded sequencer and datapath.
// Depends on bvp_pkg (curve tables, control word types, microprogram ROM).
//
// Turns one cell voltage (millivolts) into a smoothed state-of-charge percent.
// The voltage is mapped through a fixed 20-point LiPo discharge curve (0 at or
// below 3270 mV, 100 at or above 4150 mV, truncated linear interpolation in
// between), then averaged as level = (4*level + P + 2) / 5 in unsigned fixed
// point with FRAC_BITS fraction bits; the first good sample seeds the average.
// The result is the level rounded half up and limited to 100. An item with
// s_tuser set (read failed) returns error = 1, percent 0, and leaves the
// average untouched. Exactly one result item per input item, in order.
// One item at a time: s_tready is high only while the sequencer waits for
// work, and a finished result sits in the output register so the next item
// can be taken while it waits. The time per item is set by the curve walk
// (one point per cycle) and by the one-bit-per-cycle restoring divider for
// the interpolation (PCT_W steps); a read failure skips both, as does an
// out-of-range voltage. The divide by 5 of the average is a reciprocal
// multiply in one step. A held-off result holds the sequencer in its emit
// step until the output register is free.
module battery_voltage_to_percent #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] voltage_mv
    input  logic        s_tuser,    // [0] read_failed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [6:0] charge_percent, [7] zero
    output logic        m_tuser     // [0] error
);

    // Average level width: holds 100 << FRAC_BITS.
    localparam int LVL_W    = $clog2(100 * (2 ** FRAC_BITS) + 1);
    localparam int SUM_W    = LVL_W + 3;
    localparam int DW       = (SUM_W > bvp_pkg::PROD_W) ? SUM_W : bvp_pkg::PROD_W;
    localparam int CNT_W    = $clog2(bvp_pkg::PCT_W + 1);
    localparam int IDX_W    = bvp_pkg::IDX_W;
    localparam int REM_W    = bvp_pkg::REM_W;
    localparam int PCT_W    = bvp_pkg::PCT_W;

    // x / 5 == (x * ceil(2^RCP_SH / 5)) >> RCP_SH, exact for any x below 2^SUM_W
    localparam int          RCP_SH = SUM_W + 2;
    localparam logic [SUM_W-1:0] RCP5 = SUM_W'(((64'd1 << RCP_SH) + 64'd4) / 64'd5);

    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(100) << FRAC_BITS;
    localparam logic [LVL_W:0]   HALF    = (LVL_W + 1)'(1) << (FRAC_BITS - 1);

    // Sequencer
    bvp_pkg::step_t pc_reg, pc_next;
    bvp_pkg::ctrl_t ctrl;
    logic           cond_true;

    // Datapath registers
    bvp_pkg::mv_t             mv_reg, mv_next;
    logic                     failed_reg, failed_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    bvp_pkg::pct_t            pct_reg, pct_next;
    logic [bvp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [REM_W-1:0]         dvs_reg, dvs_next;
    logic [DW-1:0]            quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LVL_W-1:0]         level_reg, level_next;
    logic                     valid_reg, valid_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    bvp_pkg::pct_t            m_pct_reg, m_pct_next;
    logic                     m_err_reg, m_err_next;

    // Combinational helpers
    bvp_pkg::mv_t     mv_hi, mv_lo;
    bvp_pkg::pct_t    pct_lo, rise;
    logic             found, out_range, out_free;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [LVL_W-1:0] sample;
    logic [DW-1:0]    avg_sum;
    logic [2*SUM_W-1:0] avg_prod;
    logic [LVL_W:0]   rnd;
    logic [LVL_W:0]   rnd_int;
    bvp_pkg::pct_t    emit_pct;

    assign ctrl = bvp_pkg::ucode(pc_reg);

    assign s_tready = (pc_reg == bvp_pkg::ST_WAIT);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_pct_reg};
    assign m_tuser  = m_err_reg;

    always_comb begin
        mv_hi     = bvp_pkg::CURVE_MV[idx_reg];
        mv_lo     = bvp_pkg::CURVE_MV[idx_reg - 1'b1];
        pct_lo    = bvp_pkg::CURVE_PCT[idx_reg - 1'b1];
        rise      = bvp_pkg::CURVE_PCT[idx_reg] - pct_lo;
        found     = (mv_reg < mv_hi);
        out_range = (mv_reg <= bvp_pkg::CURVE_MV[0]) ||
                    (mv_reg >= bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1]);
        out_free  = !m_valid_reg || m_tready;

        // restoring divider step: shift one dividend bit into the remainder
        trial     = {rem_reg, quo_reg[DW-1]};
        ge        = (trial >= {1'b0, dvs_reg});

        sample    = LVL_W'(pct_reg) << FRAC_BITS;
        avg_sum   = DW'({level_reg, 2'b00}) + DW'(sample) + DW'(2);
        // registered sum times the reciprocal of 5
        avg_prod  = quo_reg[SUM_W-1:0] * RCP5;

        rnd       = {1'b0, level_reg} + HALF;
        rnd_int   = rnd >> FRAC_BITS;
        emit_pct  = (rnd_int > (LVL_W + 1)'(bvp_pkg::PCT_MAX)) ? bvp_pkg::PCT_MAX
                                                                : PCT_W'(rnd_int);
    end

    always_comb begin
        case (ctrl.cond)
            bvp_pkg::C_ALWAYS:    cond_true = 1'b1;
            bvp_pkg::C_START:     cond_true = s_tvalid;
            bvp_pkg::C_FAILED:    cond_true = failed_reg;
            bvp_pkg::C_OUT_RANGE: cond_true = out_range;
            bvp_pkg::C_FOUND:     cond_true = found;
            bvp_pkg::C_DIV_LAST:  cond_true = (cnt_reg == CNT_W'(1));
            bvp_pkg::C_VALID:     cond_true = valid_reg;
            bvp_pkg::C_OUT_BUSY:  cond_true = !out_free;
            default:              cond_true = 1'b0;
        endcase
        pc_next = cond_true ? ctrl.jmp_t : ctrl.jmp_f;
    end

    always_comb begin
        mv_next      = mv_reg;
        failed_next  = failed_reg;
        idx_next     = idx_reg;
        pct_next     = pct_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        level_next   = level_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_pct_next   = m_pct_reg;
        m_err_next   = m_err_reg;

        if (s_tvalid && s_tready) begin
            mv_next     = s_tdata;
            failed_next = s_tuser;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (ctrl.op)
            bvp_pkg::OP_NOP: begin
            end
            bvp_pkg::OP_CLAMP: begin
                pct_next = (mv_reg >= bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1])
                           ? bvp_pkg::PCT_MAX : '0;
                idx_next = IDX_W'(1);
            end
            bvp_pkg::OP_WALK: begin
                if (!found) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bvp_pkg::OP_MUL: begin
                prod_next = rise * (mv_reg - mv_lo);
                dvs_next  = mv_hi - mv_lo;
            end
            bvp_pkg::OP_DIV_INT: begin
                // quotient is below the segment rise, so PCT_W steps suffice
                rem_next = REM_W'(prod_reg >> PCT_W);
                quo_next = DW'(prod_reg) << (DW - PCT_W);
                cnt_next = CNT_W'(PCT_W);
            end
            bvp_pkg::OP_AVG_SUM: begin
                quo_next = avg_sum;
            end
            bvp_pkg::OP_DIV_STEP: begin
                rem_next = ge ? REM_W'(trial - {1'b0, dvs_reg}) : REM_W'(trial);
                quo_next = {quo_reg[DW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            bvp_pkg::OP_ADD_PCT: begin
                pct_next = pct_lo + quo_reg[PCT_W-1:0];
            end
            bvp_pkg::OP_SEED: begin
                if (!valid_reg) begin
                    level_next = sample;
                    valid_next = 1'b1;
                end
            end
            bvp_pkg::OP_STORE: begin
                level_next = LVL_W'(avg_prod >> RCP_SH);
            end
            bvp_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pct_next   = emit_pct;
                    m_err_next   = 1'b0;
                end
            end
            bvp_pkg::OP_EMIT_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pct_next   = '0;
                    m_err_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= bvp_pkg::ST_WAIT;
            valid_reg   <= 1'b0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            valid_reg   <= valid_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        mv_reg     <= mv_next;
        failed_reg <= failed_next;
        idx_reg    <= idx_next;
        pct_reg    <= pct_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        m_pct_reg  <= m_pct_next;
        m_err_reg  <= m_err_next;
    end

    // curve walk stays inside the table
    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == bvp_pkg::ST_WALK) |->
            (idx_reg >= IDX_W'(1)) && (idx_reg <= IDX_W'(bvp_pkg::CURVE_POINTS - 1)))
        else $error("curve index out of range during walk");

    // average never exceeds 100 in fixed point
    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (level_reg <= LVL_MAX))
        else $error("smoothed level above full scale");

    // interpolated percent is in range before averaging
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == bvp_pkg::ST_AVG) |-> (pct_reg <= bvp_pkg::PCT_MAX))
        else $error("sample percent above 100");

    // a new result only comes from an emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            ($past(pc_reg) == bvp_pkg::ST_OUT) || ($past(pc_reg) == bvp_pkg::ST_FAIL))
        else $error("result raised outside an emit step");

    // error results carry a zero percent
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg) |-> (m_pct_reg == '0))
        else $error("error result with nonzero percent");

endmodule
